### rtl/pfb_pkg.sv
// ----------------------------------------------------------------------------
// pfb_pkg
// Shared types and constants for the page framebuffer with refresh stream.
// ----------------------------------------------------------------------------
`default_nettype none

package pfb_pkg;

  // item kinds carried on in_tuser
  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_PLOT    = 2'd0;
  localparam cmd_t CMD_FILL    = 2'd1;
  localparam cmd_t CMD_REFRESH = 2'd2;

  // stream bytes of a page segment
  localparam logic [7:0] CTRL_CMD   = 8'h00;
  localparam logic [7:0] CTRL_DATA  = 8'h40;
  localparam logic [7:0] PAGE_BASE  = 8'hB0;
  localparam logic [7:0] COL_LOW    = 8'h00;
  localparam logic [7:0] COL_HIGH   = 8'h10;
  localparam logic [7:0] BYTE_ONES  = 8'hFF;
  localparam logic [7:0] BYTE_ZEROS = 8'h00;

  // command bytes before the data control byte
  localparam int CMD_BYTES = 6;

  // page index width, the panel is at most eight pages tall
  localparam int PAGE_W = 3;

  typedef logic [PAGE_W-1:0] page_t;

  // channel widths
  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 8;
  localparam int OUT_USER_W = 2;

endpackage : pfb_pkg

`default_nettype wire

### rtl/page_framebuffer_plot_and_refresh_top.sv
// Refresh path: the input transfer reads the frame store byte and captures the item fields;
// in ST_EMIT they pass to the output register once it is free. An on-panel plot reads, then
// writes, one frame store byte; an off-panel plot or an unused command needs no further state;
// a refresh byte waits for the output register to free; a fill writes all PANEL_WIDTH * pages bytes.
// One read-modify-write at a time on the frame store: no input item is taken outside ST_IDLE.
// Reset: a clearing pass writes zeros over all PANEL_WIDTH * pages bytes,
// one a cycle, before the first input transfer is taken.
// ----------------------------------------------------------------------------
// page_framebuffer_plot_and_refresh_top
// Vertical-byte page monochrome frame store with plot, fill and a panel
// refresh byte stream built from page command and data transfers.
// ----------------------------------------------------------------------------
`default_nettype none

module page_framebuffer_plot_and_refresh_top #(
  parameter int PANEL_WIDTH  = 128,
  parameter int PANEL_HEIGHT = 64
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_tvalid,
  output logic                              in_tready,
  // [7:0] x_pos, [15:8] y_pos, [16] pixel_on, [23:17] zero
  input  wire  [pfb_pkg::IN_DATA_W-1:0]     in_tdata,
  // [1:0] cmd
  input  wire  [pfb_pkg::IN_USER_W-1:0]     in_tuser,
  output logic                              out_tvalid,
  input  wire                               out_tready,
  // [7:0] payload_byte
  output logic [pfb_pkg::OUT_DATA_W-1:0]    out_tdata,
  // [0] starts_transfer, [1] is_data_transfer
  output logic [pfb_pkg::OUT_USER_W-1:0]    out_tuser,
  output logic                              out_tlast
);

  import pfb_pkg::*;

  localparam int PAGE_COUNT  = (PANEL_HEIGHT + 7) / 8;
  localparam int STORE_BYTES = PANEL_WIDTH * PAGE_COUNT;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int SEG_LEN     = CMD_BYTES + 1 + PANEL_WIDTH;
  localparam int OFF_W       = $clog2(SEG_LEN);
  localparam int CALC_W      = 12;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PLOT = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;
  localparam logic [1:0] ST_FILL = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] fill_cnt_r, fill_cnt_nxt;
  logic [7:0]        fill_val_r, fill_val_nxt;
  page_t             page_r, page_nxt;
  logic [OFF_W-1:0]  off_r, off_nxt;

  // item fields captured at the input transfer
  logic [ADDR_W-1:0] addr_r;
  logic [2:0]        bit_r;
  logic              on_r;
  logic [7:0]        cmd_byte_r;
  logic              use_mem_r;
  logic              start_r;
  logic              data_r;
  logic              last_r;

  // output register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_USER_W-1:0] out_user_r;
  logic                  out_last_r;

  // frame store
  logic [7:0]        mem [STORE_BYTES];
  logic [7:0]        rd_data_r;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;

  // input field decode
  cmd_t       in_cmd;
  logic [7:0] in_x;
  logic [7:0] in_y;
  logic       in_on;
  logic       in_fire;
  logic       out_free;
  logic       emit_go;

  assign in_cmd   = cmd_t'(in_tuser[1:0]);
  assign in_x     = in_tdata[7:0];
  assign in_y     = in_tdata[15:8];
  assign in_on    = in_tdata[16];
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign emit_go  = (state_r == ST_EMIT) && out_free;

  // plot address and range check
  logic [CALC_W-1:0] plot_addr_full;
  logic              plot_in_range;
  assign plot_addr_full = CALC_W'(in_x)
                        + CALC_W'(in_y[7:3]) * CALC_W'(PANEL_WIDTH);
  assign plot_in_range  = ({1'b0, in_x} < 9'(PANEL_WIDTH))
                       && ({1'b0, in_y} < 9'(PANEL_HEIGHT));

  // refresh stream position decode
  logic [CALC_W-1:0] col_full;
  logic [CALC_W-1:0] ref_addr_full;
  logic              ref_is_data;
  logic              ref_is_ctrl;
  logic [7:0]        ref_cmd_byte;
  logic              ref_start;
  logic              ref_data_xfer;
  logic              ref_last;

  assign col_full      = CALC_W'(off_r) - CALC_W'(CMD_BYTES + 1);
  assign ref_addr_full = CALC_W'(page_r) * CALC_W'(PANEL_WIDTH) + col_full;
  assign ref_is_ctrl   = (off_r == OFF_W'(CMD_BYTES));
  assign ref_is_data   = (off_r > OFF_W'(CMD_BYTES));

  always_comb begin
    ref_cmd_byte  = CTRL_CMD;
    ref_start     = 1'b0;
    ref_data_xfer = 1'b0;
    ref_last      = 1'b0;
    if (ref_is_data) begin
      ref_data_xfer = 1'b1;
      ref_last      = (page_r == PAGE_W'(PAGE_COUNT - 1))
                   && (off_r == OFF_W'(SEG_LEN - 1));
    end else if (ref_is_ctrl) begin
      ref_cmd_byte  = CTRL_DATA;
      ref_start     = 1'b1;
      ref_data_xfer = 1'b1;
    end else if (!off_r[0]) begin
      ref_cmd_byte  = CTRL_CMD;
      ref_start     = 1'b1;
    end else if (off_r == OFF_W'(1)) begin
      ref_cmd_byte  = PAGE_BASE + 8'(page_r);
    end else if (off_r == OFF_W'(3)) begin
      ref_cmd_byte  = COL_LOW;
    end else begin
      ref_cmd_byte  = COL_HIGH;
    end
  end

  // memory port control
  logic [7:0] plot_mask;
  assign plot_mask = 8'(1) << bit_r;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_r;
    mem_wdata = on_r ? (rd_data_r | plot_mask) : (rd_data_r & ~plot_mask);
    mem_re    = 1'b0;
    mem_raddr = plot_addr_full[ADDR_W-1:0];
    unique case (state_r)
      ST_PLOT: begin
        mem_we = 1'b1;
      end
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = fill_cnt_r;
        mem_wdata = fill_val_r;
      end
      ST_IDLE: begin
        if (in_fire && in_cmd == CMD_PLOT) begin
          mem_re = 1'b1;
        end else if (in_fire && in_cmd == CMD_REFRESH) begin
          mem_re    = ref_is_data;
          mem_raddr = ref_addr_full[ADDR_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  // sequencer next state
  always_comb begin
    state_nxt    = state_r;
    fill_cnt_nxt = fill_cnt_r;
    fill_val_nxt = fill_val_r;
    page_nxt     = page_r;
    off_nxt      = off_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          priority if (in_cmd == CMD_PLOT) begin
            if (plot_in_range) begin
              state_nxt = ST_PLOT;
            end
          end else if (in_cmd == CMD_FILL) begin
            state_nxt    = ST_FILL;
            fill_cnt_nxt = '0;
            fill_val_nxt = in_on ? BYTE_ONES : BYTE_ZEROS;
          end else if (in_cmd == CMD_REFRESH) begin
            state_nxt = ST_EMIT;
            if (off_r == OFF_W'(SEG_LEN - 1)) begin
              off_nxt  = '0;
              page_nxt = (page_r == PAGE_W'(PAGE_COUNT - 1)) ? '0 : page_r + 1'b1;
            end else begin
              off_nxt = off_r + 1'b1;
            end
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_PLOT: begin
        state_nxt = ST_IDLE;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FILL: begin
        if (fill_cnt_r == ADDR_W'(STORE_BYTES - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          fill_cnt_nxt = fill_cnt_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_FILL;
      fill_cnt_r <= '0;
      fill_val_r <= BYTE_ZEROS;
      page_r     <= '0;
      off_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      fill_cnt_r <= fill_cnt_nxt;
      fill_val_r <= fill_val_nxt;
      page_r     <= page_nxt;
      off_r      <= off_nxt;
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      addr_r     <= plot_addr_full[ADDR_W-1:0];
      bit_r      <= in_y[2:0];
      on_r       <= in_on;
      cmd_byte_r <= ref_cmd_byte;
      use_mem_r  <= ref_is_data;
      start_r    <= ref_start;
      data_r     <= ref_data_xfer;
      last_r     <= ref_last;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_data_r <= use_mem_r ? rd_data_r : cmd_byte_r;
      out_user_r <= {data_r, start_r};
      out_last_r <= last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule : page_framebuffer_plot_and_refresh_top

`default_nettype wire

### tb/page_framebuffer_plot_and_refresh_top_tb.sv
// ----------------------------------------------------------------------------
// page_framebuffer_plot_and_refresh_top_tb
// Drives plot, fill and refresh items into the page framebuffer and checks
// every refresh stream byte against a behavioral copy of the store and of the
// page stream position, with random gaps on input and stalls on output.
// ----------------------------------------------------------------------------

module page_framebuffer_plot_and_refresh_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pfb_pkg::*;

  localparam int PANEL_WIDTH  = 128;
  localparam int PANEL_HEIGHT = 64;
  localparam int PAGES        = (PANEL_HEIGHT + 7) / 8;
  localparam int STORE_BYTES  = PANEL_WIDTH * PAGES;
  localparam int SEGMENT_LEN  = CMD_BYTES + 1 + PANEL_WIDTH;
  localparam int CLK_PERIOD   = 4;
  localparam int IDLE_LIMIT   = 10000;
  localparam int MAX_REPORTS  = 10;

  // command code the block leaves unused
  localparam cmd_t CMD_UNUSED = 2'd3;

  // one refresh stream byte as seen on the output channel
  typedef struct packed {
    logic [7:0] payload;
    logic       opens;
    logic       in_data;
    logic       frame_end;
  } stream_byte_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [IN_USER_W-1:0]  in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  out_tlast;

  // shadow copy of the frame store and the refresh position
  logic [7:0]   panel_bytes [STORE_BYTES];
  int           scan_page;
  int           scan_offset;
  stream_byte_t stream_bytes_due [$];

  int mismatch_count = 0;
  int burst_left     = 0;
  int idle_cycles    = 0;
  logic [8:0] stall_phase = '0;

  page_framebuffer_plot_and_refresh_top #(
    .PANEL_WIDTH (PANEL_WIDTH),
    .PANEL_HEIGHT(PANEL_HEIGHT)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // next byte of the page stream, advancing the scan position
  function automatic stream_byte_t next_stream_byte();
    stream_byte_t sb;
    int col;
    sb = '0;
    if (scan_offset < CMD_BYTES) begin
      sb.opens = (scan_offset % 2 == 0);
      case (scan_offset)
        1: begin
          sb.payload = PAGE_BASE + 8'(scan_page);
        end
        3: begin
          sb.payload = COL_LOW;
        end
        5: begin
          sb.payload = COL_HIGH;
        end
        default: begin
          sb.payload = CTRL_CMD;
        end
      endcase
    end else if (scan_offset == CMD_BYTES) begin
      sb.payload = CTRL_DATA;
      sb.opens   = 1'b1;
      sb.in_data = 1'b1;
    end else begin
      col        = scan_offset - (CMD_BYTES + 1);
      sb.payload = panel_bytes[scan_page * PANEL_WIDTH + col];
      sb.in_data = 1'b1;
      sb.frame_end = (scan_page == PAGES - 1) && (scan_offset == SEGMENT_LEN - 1);
    end
    scan_offset++;
    if (scan_offset == SEGMENT_LEN) begin
      scan_offset = 0;
      scan_page   = (scan_page + 1) % PAGES;
    end
    return sb;
  endfunction

  // update the shadow state for one accepted item
  task automatic apply_item(input cmd_t cmd, input logic [7:0] x, input logic [7:0] y,
                            input logic on);
    int idx;
    case (cmd)
      CMD_PLOT: begin
        if (x < PANEL_WIDTH && y < PANEL_HEIGHT) begin
          idx = x + (y >> 3) * PANEL_WIDTH;
          panel_bytes[idx][y[2:0]] = on;
        end
      end
      CMD_FILL: begin
        foreach (panel_bytes[i]) panel_bytes[i] = on ? BYTE_ONES : BYTE_ZEROS;
      end
      CMD_REFRESH: begin
        stream_bytes_due.push_back(next_stream_byte());
      end
      default: begin
      end
    endcase
  endtask

  // send one item, with burst and gap pacing, then predict its effect
  task automatic send_item(input cmd_t cmd, input logic [7:0] x, input logic [7:0] y,
                           input logic on);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        in_tdata  <= IN_DATA_W'($urandom_range(0, 24'hFFFFFF));
        in_tuser  <= IN_USER_W'($urandom_range(0, 3));
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, on, y, x};
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
    apply_item(cmd, x, y, on);
  endtask

  task automatic flag_mismatch(input string what, input int want, input int got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("mismatch at %0t: %s expected %0h got %0h", $realtime, what, want, got);
    end
  endtask

  // receiver stall pattern: free flow, random, periodic and long stalls
  always @(negedge clk) begin
    stall_phase <= stall_phase + 9'd1;
    case (stall_phase[8:7])
      2'd0: begin
        out_tready <= 1'b1;
      end
      2'd1: begin
        out_tready <= ($urandom_range(0, 3) != 0);
      end
      2'd2: begin
        out_tready <= (stall_phase[3:0] < 4'd11);
      end
      default: begin
        out_tready <= (stall_phase[6:5] != 2'd0) && ($urandom_range(0, 1) == 1);
      end
    endcase
  end

  // compare each output transfer with the oldest predicted stream byte
  always @(posedge clk) begin
    stream_byte_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (stream_bytes_due.size() == 0) begin
        flag_mismatch("byte with nothing pending", 0, out_tdata);
      end else begin
        want = stream_bytes_due.pop_front();
        if (out_tdata !== want.payload) flag_mismatch("payload", want.payload, out_tdata);
        if (out_tuser[0] !== want.opens) flag_mismatch("starts_transfer", want.opens,
                                                        out_tuser[0]);
        if (out_tuser[1] !== want.in_data) flag_mismatch("is_data_transfer", want.in_data,
                                                          out_tuser[1]);
        if (out_tlast !== want.frame_end) flag_mismatch("frame_last", want.frame_end,
                                                         out_tlast);
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // header of page 0 and its first data byte, all cleared by reset
  task automatic test_reset_stream();
    repeat (CMD_BYTES + 2) begin
      send_item(CMD_REFRESH, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)));
    end
  endtask

  // corner pixels, pixels off the panel and the unused command
  task automatic test_plot_edges();
    send_item(CMD_PLOT, 8'd0, 8'd0, 1'b1);
    send_item(CMD_PLOT, 8'(PANEL_WIDTH - 1), 8'(PANEL_HEIGHT - 1), 1'b1);
    send_item(CMD_PLOT, 8'(PANEL_WIDTH), 8'd0, 1'b1);
    send_item(CMD_PLOT, 8'd0, 8'(PANEL_HEIGHT), 1'b1);
    send_item(CMD_PLOT, 8'd255, 8'd255, 1'b1);
    send_item(CMD_PLOT, 8'd1, 8'd7, 1'b1);
    send_item(CMD_PLOT, 8'd2, 8'd7, 1'b1);
    send_item(CMD_PLOT, 8'd1, 8'd7, 1'b0);
    send_item(CMD_UNUSED, 8'd1, 8'd7, 1'b1);
    send_item(CMD_UNUSED, 8'd255, 8'd255, 1'b0);
  endtask

  // fills between refresh bytes show from the next byte on
  task automatic test_fill_during_refresh();
    send_item(CMD_REFRESH, 8'd0, 8'd0, 1'b0);
    send_item(CMD_FILL, 8'd255, 8'd255, 1'b1);
    send_item(CMD_REFRESH, 8'd0, 8'd0, 1'b0);
    send_item(CMD_REFRESH, 8'd0, 8'd0, 1'b0);
    send_item(CMD_FILL, 8'd0, 8'd0, 1'b0);
    send_item(CMD_REFRESH, 8'd0, 8'd0, 1'b0);
  endtask

  // mostly refresh and on-panel plots, with fills, stray plots and noise
  task automatic test_random_traffic(input int count);
    int pick;
    logic [7:0] x;
    logic [7:0] y;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      x = 8'($urandom_range(0, 255));
      y = 8'($urandom_range(0, 255));
      if (pick < 72) begin
        send_item(CMD_REFRESH, x, y, 1'($urandom_range(0, 1)));
      end else if (pick < 92) begin
        x = 8'($urandom_range(0, PANEL_WIDTH - 1));
        y = 8'($urandom_range(0, PANEL_HEIGHT - 1));
        send_item(CMD_PLOT, x, y, 1'($urandom_range(0, 1)));
      end else if (pick < 95) begin
        send_item(CMD_PLOT, x, y, 1'($urandom_range(0, 1)));
      end else if (pick < 97) begin
        send_item(CMD_FILL, x, y, 1'($urandom_range(0, 1)));
      end else begin
        send_item(CMD_UNUSED, x, y, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    foreach (panel_bytes[i]) panel_bytes[i] = BYTE_ZEROS;
    scan_page   = 0;
    scan_offset = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_stream();
    test_plot_edges();
    test_fill_during_refresh();
    test_random_traffic(1930);

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (stream_bytes_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule : page_framebuffer_plot_and_refresh_top_tb
